// File: rtl/egbw_pkg.sv
// egbw_pkg: shared types and constants of the exp-golomb bit writer
`timescale 1ns / 1ps

package egbw_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned IdxW      = 24;
  localparam int unsigned CmdDepth  = 2;
  localparam int unsigned ResDepth  = 2;
  localparam logic [IdxW-1:0] CapReset = 24'hFFFFFF;

  typedef enum logic [1:0] {
    OpRaw   = 2'd0,
    OpUe    = 2'd1,
    OpSe    = 2'd2,
    OpAlign = 2'd3
  } op_e;

  typedef struct packed {
    op_e              opcode;
    logic [WordW-1:0] value;
    logic [5:0]       bit_count;
  } in_t;

  typedef struct packed {
    logic [7:0]      out_byte;
    logic [IdxW-1:0] byte_index;
    logic            beyond_capacity;
    logic            last_of_run;
  } out_t;

  // classified request: leading zeros, then data_len bits of data from the msb
  typedef struct packed {
    logic             is_align;
    logic [4:0]       zeros;
    logic [WordW-1:0] data;
    logic [5:0]       data_len;
  } cmd_t;

endpackage

// File: rtl/exp_golomb_bit_writer_unit.sv
// exp_golomb_bit_writer_unit: top level of the exp-golomb bitstream writer
//
//   channel   handshake            payload
//   request   push / full          item_i (in_t)
//   result    empty / pop          res_o (out_t)
//   config    cfg_valid_i / ready  cfg_data_i (capacity in bytes)
//
// a request is held in the front register, then passes through the command queue into
// the packer's current-request registers; its bytes leave through the result queue
// to the result ports
// the packer takes one step per byte position a request touches, each byte it
// completes plus the partial byte it leaves, at least one and up to 9 for a
// 63-bit code; requests within one byte position follow at one per cycle while
// the result queue is not full; a full result queue holds the packer, a full
// command queue holds the front stage and with it the request side
// reset clears the partial byte, the byte counter and all queues at once;
// capacity resets to all ones
`timescale 1ns / 1ps

module exp_golomb_bit_writer_unit import egbw_pkg::*; #(
  parameter int unsigned CmdQDepth = CmdDepth,
  parameter int unsigned ResQDepth = ResDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  input  in_t             item_i,
  output logic            full,
  output logic            empty,
  input  logic            pop,
  output out_t            res_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [IdxW-1:0] cfg_data_i
);

  logic [IdxW-1:0] cap_q;

  cmd_t front_cmd;
  logic front_valid;
  logic cmdq_full;
  cmd_t cmdq_data;
  logic cmdq_empty;
  logic back_ready;

  out_t back_res;
  logic back_push;
  logic resq_full;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  egbw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (item_i),
    .full_o      (full),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (!cmdq_full)
  );

  egbw_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (CmdQDepth)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_cmd),
    .full_o  (cmdq_full),
    .pop_i   (back_ready),
    .data_o  (cmdq_data),
    .empty_o (cmdq_empty)
  );

  egbw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmdq_data),
    .cmd_valid_i (!cmdq_empty),
    .cmd_ready_o (back_ready),
    .res_o       (back_res),
    .res_push_o  (back_push),
    .res_full_i  (resq_full),
    .cap_i       (cap_q)
  );

  egbw_fifo #(
    .Width ($bits(out_t)),
    .Depth (ResQDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (back_push),
    .data_i  (back_res),
    .full_o  (resq_full),
    .pop_i   (pop),
    .data_o  (res_o),
    .empty_o (empty)
  );

endmodule

// File: rtl/egbw_fifo.sv
// egbw_fifo: small register fifo used between the stages and at the result side
`timescale 1ns / 1ps

module egbw_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/egbw_front.sv
// egbw_front: accepts requests, forms the code word and classifies it
`timescale 1ns / 1ps

module egbw_front import egbw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  in_t  item_i,
  output logic full_o,
  output cmd_t cmd_o,
  output logic cmd_valid_o,
  input  logic cmd_ready_i
);

  logic             a_valid_q, a_valid_d;
  op_e              a_op_q;
  logic [WordW-1:0] a_code_q;
  logic [5:0]       a_n_q;
  logic             accept;

  logic [WordW-1:0] code;
  logic [WordW-1:0] sv_sat;
  logic [WordW-1:0] mag;
  logic [5:0]       raw_n;

  logic [WordW-1:0] norm;
  logic [4:0]       clz;

  assign full_o      = a_valid_q && !cmd_ready_i;
  assign accept      = push_i && !full_o;
  assign cmd_valid_o = a_valid_q;
  assign a_valid_d   = accept ? 1'b1 : (cmd_ready_i ? 1'b0 : a_valid_q);

  // code word before the length search
  always_comb begin
    sv_sat = (item_i.value == 32'h8000_0000) ? 32'h8000_0001 : item_i.value;
    mag    = ~sv_sat + 32'd1;
    raw_n  = (item_i.bit_count > 6'd32) ? 6'd32 : item_i.bit_count;
    code   = item_i.value;
    unique case (item_i.opcode)
      OpRaw:   code = item_i.value;
      OpUe:    code = item_i.value + 32'd1;
      OpSe: begin
        // mapped + 1: 2v for positive, 2|v| + 1 for negative, 1 for zero
        if (sv_sat == '0) begin
          code = 32'd1;
        end else if (!sv_sat[31]) begin
          code = {sv_sat[30:0], 1'b0};
        end else begin
          code = {mag[30:0], 1'b1};
        end
      end
      OpAlign: code = '0;
      default: code = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_op_q   <= item_i.opcode;
      a_code_q <= code;
      a_n_q    <= raw_n;
    end
  end

  // binary search normalize: leaves the leading one in the msb
  always_comb begin
    norm = a_code_q;
    clz  = '0;
    if (norm[31:16] == '0) begin
      norm   = norm << 16;
      clz[4] = 1'b1;
    end
    if (norm[31:24] == '0) begin
      norm   = norm << 8;
      clz[3] = 1'b1;
    end
    if (norm[31:28] == '0) begin
      norm   = norm << 4;
      clz[2] = 1'b1;
    end
    if (norm[31:30] == '0) begin
      norm   = norm << 2;
      clz[1] = 1'b1;
    end
    if (!norm[31]) begin
      norm   = norm << 1;
      clz[0] = 1'b1;
    end
  end

  always_comb begin
    cmd_o = '0;
    unique case (a_op_q)
      OpRaw: begin
        cmd_o.data     = a_code_q << (6'd32 - a_n_q);
        cmd_o.data_len = a_n_q;
      end
      OpUe, OpSe: begin
        // zero code (wrapped all-ones) writes nothing
        if (norm[31]) begin
          cmd_o.zeros    = ~clz;
          cmd_o.data     = norm;
          cmd_o.data_len = 6'd32 - {1'b0, clz};
        end
      end
      OpAlign: cmd_o.is_align = 1'b1;
      default: cmd_o = '0;
    endcase
  end

endmodule

// File: rtl/egbw_back.sv
// egbw_back: packs classified requests into bytes, at most one byte per cycle while the result queue is not full
`timescale 1ns / 1ps

module egbw_back import egbw_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmd_t            cmd_i,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  output out_t            res_o,
  output logic            res_push_o,
  input  logic            res_full_i,
  input  logic [IdxW-1:0] cap_i
);

  logic             cur_valid_q, cur_valid_d;
  logic             cur_align_q, cur_align_d;
  logic [4:0]       rz_q, rz_d;
  logic [WordW-1:0] dsr_q, dsr_d;
  logic [5:0]       rn_q, rn_d;
  logic [7:0]       partial_q, partial_d;
  logic [2:0]       filled_q, filled_d;
  logic [IdxW-1:0]  idx_q, idx_d;

  logic [5:0] avail;
  logic [3:0] free;
  logic [3:0] k;
  logic [7:0] chunk;
  logic [7:0] topk;
  logic [7:0] merged;
  logic [3:0] fill_sum;
  logic [5:0] rest;
  logic [3:0] dn;
  logic       step;
  logic       emit;
  logic       done;

  assign avail    = {1'b0, rz_q} + rn_q;
  assign free     = 4'd8 - {1'b0, filled_q};
  assign k        = ({2'b0, free} > avail) ? avail[3:0] : free;
  assign chunk    = (rz_q >= 5'd8) ? 8'h00 : (dsr_q[31:24] >> rz_q[2:0]);
  assign topk     = chunk & ~(8'hFF >> k);
  assign merged   = partial_q | (topk >> filled_q);
  assign fill_sum = {1'b0, filled_q} + k;
  assign rest     = avail - {2'b0, k};
  assign dn       = k - rz_q[3:0];

  assign step = cur_valid_q && !res_full_i;
  assign emit = step && (cur_align_q ? (filled_q != '0) : (fill_sum == 4'd8));
  assign done = step && (cur_align_q || (rest == '0));

  assign cmd_ready_o = !cur_valid_q || done;
  assign res_push_o  = emit;

  always_comb begin
    res_o.out_byte        = cur_align_q ? partial_q : merged;
    res_o.byte_index      = idx_q;
    res_o.beyond_capacity = (idx_q >= cap_i);
    // nothing more of this request can fill a whole byte
    res_o.last_of_run     = cur_align_q || (rest < 6'd8);
  end

  always_comb begin
    cur_valid_d = cur_valid_q;
    cur_align_d = cur_align_q;
    rz_d        = rz_q;
    dsr_d       = dsr_q;
    rn_d        = rn_q;
    partial_d   = partial_q;
    filled_d    = filled_q;
    idx_d       = idx_q;

    if (step) begin
      if (cur_align_q || fill_sum == 4'd8) begin
        partial_d = '0;
        filled_d  = '0;
      end else begin
        partial_d = merged;
        filled_d  = fill_sum[2:0];
      end
      if (rz_q >= {1'b0, k}) begin
        rz_d = rz_q - {1'b0, k};
      end else begin
        rz_d  = '0;
        dsr_d = dsr_q << dn;
        rn_d  = rn_q - {2'b0, dn};
      end
      if (done) begin
        cur_valid_d = 1'b0;
      end
    end
    if (emit) begin
      idx_d = idx_q + IdxW'(1);
    end
    if (cmd_valid_i && cmd_ready_o) begin
      cur_valid_d = 1'b1;
      cur_align_d = cmd_i.is_align;
      rz_d        = cmd_i.zeros;
      dsr_d       = cmd_i.data;
      rn_d        = cmd_i.data_len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      partial_q   <= '0;
      filled_q    <= '0;
      idx_q       <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      partial_q   <= partial_d;
      filled_q    <= filled_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_align_q <= cur_align_d;
    rz_q        <= rz_d;
    dsr_q       <= dsr_d;
    rn_q        <= rn_d;
  end

endmodule

// File: bench/exp_golomb_bit_writer_unit_tb.sv
// exp_golomb_bit_writer_unit_tb: self-checking bench for the exp-golomb bitstream writer
`timescale 1ns / 1ps

module exp_golomb_bit_writer_unit_tb;
  import egbw_pkg::*;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned DrainWait  = 12;
  localparam int unsigned IdlePct    = 11;

  logic            clk_i     = 1'b0;
  logic            rst_ni    = 1'b0;
  logic            push      = 1'b0;
  in_t             item      = '0;
  logic            full;
  logic            empty;
  logic            pop       = 1'b0;
  out_t            res;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [IdxW-1:0] cfg_data  = '0;

  exp_golomb_bit_writer_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .item_i      (item),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // packer model: bits collected msb first, byte counter, capacity
  logic [7:0]      pk_byte   = '0;
  int unsigned     pk_fill   = 0;
  logic [IdxW-1:0] pk_index  = '0;
  logic [IdxW-1:0] cap_model = CapReset;

  out_t run_q[$];
  out_t byte_q[$];
  in_t  pending_q[$];

  bit          calm         = 1'b1;
  int unsigned hold_req     = 0;
  int unsigned hold_served  = 0;
  int unsigned hold_left    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_fail       = 0;
  int unsigned n_items      = 0;
  int unsigned n_bytes      = 0;
  int unsigned n_cfg        = 0;
  int unsigned n_op[4]      = '{default: 0};
  out_t        want;

  function automatic void flush_byte();
    out_t r;
    r.out_byte        = pk_byte;
    r.byte_index      = pk_index;
    r.beyond_capacity = (pk_index >= cap_model);
    r.last_of_run     = 1'b0;
    run_q.push_back(r);
    pk_index = pk_index + 1'b1;
    pk_byte  = '0;
    pk_fill  = 0;
  endfunction

  function automatic void shift_bits(logic [63:0] bits, int n);
    for (int i = n - 1; i >= 0; i--) begin
      pk_byte[7 - pk_fill] = bits[i];
      pk_fill++;
      if (pk_fill == 8) flush_byte();
    end
  endfunction

  function automatic void shift_ue(logic [31:0] v);
    logic [31:0] code;
    int          len;
    code = v + 1'b1;
    len  = 0;
    for (int b = 31; b >= 0; b--) begin
      if (code[b]) begin
        len = b + 1;
        break;
      end
    end
    // all-ones wraps to zero: nothing written
    if (len != 0) shift_bits({32'b0, code}, 2 * len - 1);
  endfunction

  function automatic void encode_request(in_t rq);
    logic [31:0] v;
    logic [31:0] mapped;
    out_t        tail;
    int          n;
    run_q.delete();
    v = rq.value;
    case (rq.opcode)
      OpRaw: begin
        n = (rq.bit_count > 6'd32) ? 32 : int'(rq.bit_count);
        shift_bits({32'b0, v}, n);
      end
      OpUe: shift_ue(v);
      OpSe: begin
        if (v == 32'h8000_0000) v = 32'h8000_0001;
        if (v == '0) mapped = '0;
        else if (!v[31]) mapped = 2 * v - 1;
        else mapped = 2 * (-v);
        shift_ue(mapped);
      end
      default: begin
        if (pk_fill != 0) flush_byte();
      end
    endcase
    if (run_q.size() != 0) begin
      tail = run_q.pop_back();
      tail.last_of_run = 1'b1;
      run_q.push_back(tail);
    end
    foreach (run_q[i]) byte_q.push_back(run_q[i]);
  endfunction

  function automatic in_t req(op_e op, logic [31:0] v, logic [5:0] n);
    in_t it;
    it.opcode    = op;
    it.value     = v;
    it.bit_count = n;
    return it;
  endfunction

  // mostly short codes, some mid-size, a few full-width values
  function automatic logic [31:0] pick_symbol();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 6) return $urandom_range(0, 40);
    if (r < 9) return $urandom_range(0, 70000);
    return $urandom;
  endfunction

  function automatic in_t rand_request();
    in_t         it;
    int unsigned pick;
    it.value     = $urandom;
    it.bit_count = 6'($urandom_range(0, 63));
    pick = $urandom_range(99);
    if (pick < 30) begin
      it.opcode = OpRaw;
      if ($urandom_range(3) != 0) it.bit_count = 6'($urandom_range(0, 32));
    end else if (pick < 60) begin
      it.opcode = OpUe;
      it.value  = pick_symbol();
    end else if (pick < 85) begin
      it.opcode = OpSe;
      it.value  = pick_symbol();
      if ($urandom_range(1) != 0) it.value = -it.value;
    end else begin
      it.opcode = OpAlign;
    end
    return it;
  endfunction

  task automatic load_random(int unsigned count);
    repeat (count) pending_q.push_back(rand_request());
  endtask

  task automatic write_capacity(logic [IdxW-1:0] cap);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // align requests and the packer stage may still be busy after the last byte
  task automatic wait_drained();
    while (pending_q.size() != 0 || push || byte_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        encode_request(item);
        n_items++;
        n_op[item.opcode]++;
      end
      if (push && full) begin
        // hold the offered transfer
      end else if (pending_q.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
        push <= 1'b1;
        item <= pending_q.pop_front();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // result monitor and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        n_bytes++;
        if (byte_q.size() == 0) begin
          $error("unexpected byte 0x%02h at index %0d", res.out_byte, res.byte_index);
          n_fail++;
        end else begin
          want = byte_q.pop_front();
          if (res.out_byte !== want.out_byte) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, res.out_byte);
            n_fail++;
          end
          if (res.byte_index !== want.byte_index) begin
            $error("byte_index: expected %0d, got %0d", want.byte_index, res.byte_index);
            n_fail++;
          end
          if (res.beyond_capacity !== want.beyond_capacity) begin
            $error("beyond_capacity: expected %0b, got %0b",
                   want.beyond_capacity, res.beyond_capacity);
            n_fail++;
          end
          if (res.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run, res.last_of_run);
            n_fail++;
          end
        end
      end
      // long hold-off so the queues fill and full backs up the sender
      if (hold_left != 0) begin
        pop       <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_served != hold_req) begin
        hold_served <= hold_req;
        hold_left   <= HoldCycles;
        pop         <= 1'b0;
      end else begin
        pop <= calm || $urandom_range(99) >= IdlePct;
      end
    end
  end

  always @(posedge clk_i) begin
    if (cfg_valid && cfg_ready) begin
      cap_model = cfg_data;
      n_cfg++;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed requests at reset capacity, no idling
    pending_q.push_back(req(OpRaw,   32'h0000_0001, 6'd1));
    pending_q.push_back(req(OpAlign, 32'hFFFF_FFFF, 6'd63));
    pending_q.push_back(req(OpAlign, 32'h0000_0000, 6'd0));
    pending_q.push_back(req(OpRaw,   32'hFFFF_FFFF, 6'd32));
    pending_q.push_back(req(OpRaw,   32'h0000_FFFF, 6'd0));
    pending_q.push_back(req(OpRaw,   32'h0F0F_0F0F, 6'd63));
    pending_q.push_back(req(OpRaw,   32'h0000_0055, 6'd7));
    pending_q.push_back(req(OpUe,    32'h0000_0000, 6'd0));
    pending_q.push_back(req(OpUe,    32'h0000_0001, 6'd0));
    pending_q.push_back(req(OpUe,    32'hFFFF_FFFF, 6'd0));
    pending_q.push_back(req(OpUe,    32'hFFFF_FFFE, 6'd0));
    pending_q.push_back(req(OpUe,    32'h7FFF_FFFF, 6'd0));
    pending_q.push_back(req(OpSe,    32'h0000_0000, 6'd0));
    pending_q.push_back(req(OpSe,    32'h0000_0001, 6'd0));
    pending_q.push_back(req(OpSe,    32'hFFFF_FFFF, 6'd0));
    pending_q.push_back(req(OpSe,    32'h8000_0000, 6'd0));
    pending_q.push_back(req(OpSe,    32'h8000_0001, 6'd0));
    pending_q.push_back(req(OpSe,    32'h7FFF_FFFF, 6'd0));
    pending_q.push_back(req(OpRaw,   32'hA5A5_A5A5, 6'd40));
    pending_q.push_back(req(OpRaw,   32'h0000_0003, 6'd5));
    pending_q.push_back(req(OpAlign, 32'h1234_5678, 6'd17));
    wait_drained();

    calm = 1'b0;
    write_capacity('0);
    load_random(35);
    wait_drained();

    // capacity just ahead of the stream so the flag flips mid-phase
    write_capacity(pk_index + IdxW'(20));
    hold_req++;
    load_random(35);
    wait_drained();

    write_capacity(24'hFFFFFF);
    load_random(35);
    wait_drained();

    calm = 1'b1;
    write_capacity(pk_index + IdxW'($urandom_range(0, 60)));
    load_random(35);
    wait_drained();

    $display("covered %0d requests (raw %0d, ue %0d, se %0d, align %0d), %0d bytes checked,",
             n_items, n_op[OpRaw], n_op[OpUe], n_op[OpSe], n_op[OpAlign], n_bytes);
    $display("%0d capacity writes including zero and all ones, one long result hold-off", n_cfg);
    if (n_fail == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
